### rtl/rational_polyphase_resampler_defines.svh
`ifndef RATIONAL_POLYPHASE_RESAMPLER_DEFINES_SVH
`define RATIONAL_POLYPHASE_RESAMPLER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RPR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RPR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rpr_pkg.sv
package rpr_pkg;

	// default sizes
	localparam int MAX_TAPS_DEF      = 16384;
	localparam int HISTORY_DEPTH_DEF = 2048;
	localparam int MAX_OUT_DEF       = 4;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int COEFF_W    = 18;
	localparam int COEFF_IX_W = 14;
	localparam int FACTOR_W   = 10;
	localparam int TAP_W      = 15;
	localparam int CUR_W      = FACTOR_W + 1;
	localparam int PROD_W     = SAMPLE_W + COEFF_W;
	localparam int ACC_W      = 48;
	localparam int RND_SHIFT  = 17;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = TAP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTERP = 2'd0,
		CFG_DECIM  = 2'd1,
		CFG_TAPS   = 2'd2
	} cfg_reg_t;

	localparam logic [FACTOR_W-1:0] INTERP_RST = 10'd13;
	localparam logic [FACTOR_W-1:0] DECIM_RST  = 10'd50;
	localparam logic [TAP_W-1:0]    TAPS_RST   = 15'd14057;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_COEFF  = 1'b1
	} req_t;

	// controller to datapath
	typedef struct packed {
		logic take_sample;
		logic take_coeff;
		logic start_out;
		logic issue;
		logic skip;
		logic load_out;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cur_lt_l;
		logic cnt_full;
		logic issue_more;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

### rtl/rpr_if.sv
interface rpr_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic signed [15:0] sample_in;
	logic [13:0] coeff_index;
	logic signed [17:0] coeff_value;

	modport source (output valid, req_type, sample_in, coeff_index, coeff_value, input ready);
	modport sink (input valid, req_type, sample_in, coeff_index, coeff_value, output ready);
endinterface

interface rpr_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] sample_out;
	logic        last_of_run;
	logic        saturated;
	logic        dropped;

	modport source (output valid, sample_out, last_of_run, saturated, dropped, input ready);
	modport sink (input valid, sample_out, last_of_run, saturated, dropped, output ready);
endinterface

### rtl/rpr_ram.sv
module rpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/rpr_ctrl.sv
module rpr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          req_type,
	output logic          in_ready,
	input  rpr_pkg::sts_t sts,
	output rpr_pkg::cmd_t cmd
);
	import rpr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_MAC   = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// sequencing of samples, outputs and taps
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_COEFF) begin
						cmd.take_coeff = 1'b1;
					end else begin
						cmd.take_sample = 1'b1;
						state_nxt       = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (sts.cur_lt_l && !sts.cnt_full) begin
					cmd.start_out = 1'b1;
					state_nxt     = ST_MAC;
				end else if (sts.cur_lt_l) begin
					cmd.skip = 1'b1;
				end else begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			ST_MAC: begin
				if (sts.issue_more) begin
					cmd.issue = 1'b1;
				end else begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_CHECK;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end
endmodule

### rtl/rpr_dp.sv
module rpr_dp #(
	parameter int MAX_TAPS      = rpr_pkg::MAX_TAPS_DEF,
	parameter int HISTORY_DEPTH = rpr_pkg::HISTORY_DEPTH_DEF,
	parameter int MAX_OUT       = rpr_pkg::MAX_OUT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [rpr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rpr_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic signed [rpr_pkg::SAMPLE_W-1:0]    sample_in,
	input  logic [rpr_pkg::COEFF_IX_W-1:0]         coeff_index,
	input  logic signed [rpr_pkg::COEFF_W-1:0]     coeff_value,
	input  rpr_pkg::cmd_t                          cmd,
	output rpr_pkg::sts_t                          sts,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic signed [rpr_pkg::SAMPLE_W-1:0]    sample_out,
	output logic                                   last_of_run,
	output logic                                   saturated,
	output logic                                   dropped
);
	import rpr_pkg::*;

	localparam int CAW  = $clog2(MAX_TAPS);
	localparam int HAW  = $clog2(HISTORY_DEPTH);
	localparam int MW   = $clog2(HISTORY_DEPTH + 1);
	localparam int CW   = $clog2(MAX_TAPS + 2048);
	localparam int EW   = (CW > TAP_W) ? CW : TAP_W;
	localparam int CNTW = $clog2(MAX_OUT + 1);
	localparam logic [HAW-1:0]  HIST_LAST = HAW'(HISTORY_DEPTH - 1);
	localparam logic [MW-1:0]   HIST_FULL = MW'(HISTORY_DEPTH);
	localparam logic [CNTW-1:0] CNT_MAX   = CNTW'(MAX_OUT);
	localparam logic [CNTW-1:0] CNT_LAST  = CNTW'(MAX_OUT - 1);
	localparam logic [CW-1:0]   TAPS_LIM  = CW'(MAX_TAPS);

	// configuration registers
	logic [FACTOR_W-1:0] interp_q, decim_q;
	logic [TAP_W-1:0]    taps_q;
	logic [FACTOR_W-1:0] l_eff, m_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q <= INTERP_RST;
			decim_q  <= DECIM_RST;
			taps_q   <= TAPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INTERP: interp_q <= cfg_data[FACTOR_W-1:0];
				CFG_DECIM:  decim_q  <= cfg_data[FACTOR_W-1:0];
				CFG_TAPS:   taps_q   <= cfg_data[TAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign l_eff = (interp_q == '0) ? FACTOR_W'(1) : interp_q;
	assign m_eff = (decim_q == '0) ? FACTOR_W'(1) : decim_q;

	// stream state and per-output counters
	logic [HAW-1:0]      wptr_q, w_q, rd_q;
	logic [MW-1:0]       fill_q, m_q;
	logic [FACTOR_W-1:0] phase_q;
	logic [CUR_W-1:0]    cur_q, cur_next;
	logic [CNTW-1:0]     cnt_q;
	logic [CW-1:0]       c_q;
	logic                v_s1, v_s2;
	logic                coeff_ok;

	assign cur_next = cur_q + CUR_W'(m_eff);
	assign coeff_ok = (32'(coeff_index) < 32'(MAX_TAPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			fill_q  <= '0;
			phase_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.take_sample) begin
				wptr_q <= (wptr_q == HIST_LAST) ? '0 : wptr_q + HAW'(1);
				if (fill_q != HIST_FULL) begin
					fill_q <= fill_q + MW'(1);
				end
			end
			if (cmd.finish) begin
				phase_q <= FACTOR_W'(cur_q - CUR_W'(l_eff));
			end
		end
	end

	// walk of the current output through taps and history
	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			w_q   <= wptr_q;
			cur_q <= CUR_W'(phase_q);
			cnt_q <= '0;
		end
		if (cmd.skip) begin
			cur_q <= cur_next;
		end
		if (cmd.load_out) begin
			cur_q <= cur_next;
			cnt_q <= cnt_q + CNTW'(1);
		end
		if (cmd.start_out) begin
			c_q  <= CW'(cur_q);
			m_q  <= '0;
			rd_q <= w_q;
		end
		if (cmd.issue) begin
			c_q  <= c_q + CW'(l_eff);
			m_q  <= m_q + MW'(1);
			rd_q <= (rd_q == '0) ? HIST_LAST : rd_q - HAW'(1);
		end
	end

	// memories
	logic [SAMPLE_W-1:0] hist_rdata;
	logic [COEFF_W-1:0]  coef_rdata;

	rpr_ram #(.WIDTH(SAMPLE_W), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.we    (cmd.take_sample),
		.waddr (wptr_q),
		.wdata (sample_in),
		.raddr (rd_q),
		.rdata (hist_rdata)
	);

	rpr_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TAPS)) u_coef (
		.clk   (clk),
		.we    (cmd.take_coeff && coeff_ok),
		.waddr (CAW'(coeff_index)),
		.wdata (coeff_value),
		.raddr (c_q[CAW-1:0]),
		.rdata (coef_rdata)
	);

	// multiply and accumulate
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(hist_rdata) * $signed(coef_rdata);
		if (cmd.start_out) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// round half up to Q1.15 and clip
	logic signed [ACC_W-1:0] rnd, quo;
	logic                    sat_hi, sat_lo, next_due, at_last;

	assign rnd      = acc_q + ACC_W'(65536);
	assign quo      = rnd >>> RND_SHIFT;
	assign sat_hi   = (quo > ACC_W'(32767));
	assign sat_lo   = (quo < -ACC_W'(32768));
	assign next_due = (cur_next < CUR_W'(l_eff));
	assign at_last  = (cnt_q == CNT_LAST);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_out  <= sat_hi ? 16'sh7fff : (sat_lo ? 16'sh8000 : quo[SAMPLE_W-1:0]);
			saturated   <= sat_hi || sat_lo;
			last_of_run <= !next_due || at_last;
			dropped     <= at_last && next_due;
		end
	end

	// status
	assign sts.cur_lt_l   = (cur_q < CUR_W'(l_eff));
	assign sts.cnt_full   = (cnt_q == CNT_MAX);
	assign sts.issue_more = (EW'(c_q) < EW'(taps_q)) && (c_q < TAPS_LIM) && (m_q < fill_q);
	assign sts.pipe_busy  = v_s1 || v_s2;
	assign sts.out_free   = !out_valid || out_ready;
endmodule

### rtl/rational_polyphase_resampler.sv
// an output walks N taps, N = taps used (taps reachable at this phase, limited by
//   the samples held in history), then drains the MAC into the output register once free
// input is taken only in idle, after every output of the last sample is walked or
//   skipped as discarded; the single MAC over the two RAM read ports sets this pace
// a coefficient load keeps the block idle; reset restores default factors, empties history
//   via a fill count (no clearing pass), coefficient RAM stays undefined until written
module rational_polyphase_resampler #(
	parameter int MAX_TAPS              = rpr_pkg::MAX_TAPS_DEF,
	parameter int HISTORY_DEPTH         = rpr_pkg::HISTORY_DEPTH_DEF,
	parameter int MAX_OUTPUTS_PER_INPUT = rpr_pkg::MAX_OUT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpr_pkg::CFG_DATA_W-1:0] cfg_data,
	rpr_in_if.sink                         in_ch,
	rpr_out_if.source                      out_ch
);
	import rpr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	rpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.req_type (in_ch.req_type),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// memories, MAC and output register
	rpr_dp #(
		.MAX_TAPS      (MAX_TAPS),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.MAX_OUT       (MAX_OUTPUTS_PER_INPUT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_in   (in_ch.sample_in),
		.coeff_index (in_ch.coeff_index),
		.coeff_value (in_ch.coeff_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.sample_out  (out_ch.sample_out),
		.last_of_run (out_ch.last_of_run),
		.saturated   (out_ch.saturated),
		.dropped     (out_ch.dropped)
	);
endmodule

### rtl/rpr_checker.sv
`include "rational_polyphase_resampler_defines.svh"

module rpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        req_type,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] sample_out,
	input logic        saturated,
	input logic        dropped,
	input logic        last_of_run
);
	import rpr_pkg::*;

	// a waiting beat stays offered
	`RPR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat withdrawn")
	// a coefficient load never produces a beat
	`RPR_ASSERT_NXT(a_load_quiet, in_valid && in_ready && req_type == REQ_COEFF && !out_valid, !out_valid, "beat after coefficient load")
	// a sample keeps the block busy for the next cycle
	`RPR_ASSERT_NXT(a_sample_busy, in_valid && in_ready && req_type == REQ_SAMPLE, !in_ready, "ready right after a sample")
	// clipped outputs sit on a rail
	`RPR_ASSERT_IMP(a_sat_rail, out_valid && saturated, sample_out == 16'h7fff || sample_out == 16'h8000, "saturated beat off the rail")
	// drop flag only closes a run
	`RPR_ASSERT_IMP(a_drop_last, out_valid && dropped, last_of_run, "drop flag on a non-final beat")
endmodule

bind rational_polyphase_resampler rpr_checker u_rpr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.req_type    (in_ch.req_type),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.sample_out  (out_ch.sample_out),
	.saturated   (out_ch.saturated),
	.dropped     (out_ch.dropped),
	.last_of_run (out_ch.last_of_run)
);

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rpr_pkg::*;

	localparam int N_TAPS     = 16384;
	localparam int N_HIST     = 2048;
	localparam int N_OUT      = 4;
	localparam int N_FILL     = 96;
	localparam int DRAIN_WAIT = 9000;
	localparam int CYCLE_MAX  = 3000000;

	typedef struct {
		req_t               kind;
		logic signed [15:0] smp;
		logic [13:0]        cix;
		logic signed [17:0] cval;
	} req_beat_t;

	typedef struct {
		logic signed [15:0] smp;
		logic               last;
		logic               sat;
		logic               drop;
	} out_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rpr_in_if  in_ch();
	rpr_out_if out_ch();

	rational_polyphase_resampler uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	// resampler shadow state
	int unsigned l_fac, m_fac, tap_reg;
	int          coeff_mem [N_TAPS];
	int          hist_mem [N_HIST];
	int unsigned hist_wr, out_phase;

	req_beat_t pending_reqs[$];
	out_beat_t expected_outs[$];
	int        send_idle_pct, recv_stall_pct;
	int        errors, cycles, outs_seen, samples_sent, loads_sent;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_MAX) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// filtered sum for one output at coefficient offset ph
	function automatic longint filter_sum(int unsigned ph, int unsigned w,
			int unsigned lf, int unsigned nt);
		longint      acc;
		int unsigned m, c, slot;
		acc = 0;
		m = 0;
		c = ph;
		while (c < nt && m < N_HIST) begin
			slot = (w + N_HIST - m) % N_HIST;
			acc += longint'(hist_mem[slot]) * longint'(coeff_mem[c]);
			m++;
			c += lf;
		end
		return acc;
	endfunction

	// predict the outputs caused by one accepted beat
	function automatic void predict_outputs(req_beat_t b);
		int unsigned lf, mf, nt, w, due, emit;
		longint      acc, q;
		out_beat_t   o;
		if (b.kind == REQ_COEFF) begin
			coeff_mem[b.cix] = int'(b.cval);
			return;
		end
		lf = (l_fac == 0) ? 1 : l_fac;
		mf = (m_fac == 0) ? 1 : m_fac;
		nt = (tap_reg > N_TAPS) ? N_TAPS : tap_reg;
		w = hist_wr % N_HIST;
		hist_mem[w] = int'(b.smp);
		hist_wr = (w + 1) % N_HIST;
		due = (out_phase < lf) ? (lf - out_phase + mf - 1) / mf : 0;
		emit = (due > N_OUT) ? N_OUT : due;
		for (int i = 0; i < emit; i++) begin
			acc = filter_sum(out_phase + i * mf, w, lf, nt);
			q = (acc + 65536) >>> 17;
			o.sat = 1'b0;
			if (q > 32767) begin
				q = 32767;
				o.sat = 1'b1;
			end
			if (q < -32768) begin
				q = -32768;
				o.sat = 1'b1;
			end
			o.smp = q[15:0];
			o.last = (i + 1 == emit);
			o.drop = o.last && (due > emit);
			expected_outs.push_back(o);
		end
		out_phase = out_phase + due * mf - lf;
	endfunction

	// input driver
	always @(posedge clk) begin
		req_beat_t b;
		if (arst_n && (!in_ch.valid || in_ch.ready)) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				b = pending_reqs.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.req_type <= b.kind;
				in_ch.sample_in <= b.smp;
				in_ch.coeff_index <= b.cix;
				in_ch.coeff_value <= b.cval;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// accepted input beats feed the predictor
	always @(posedge clk) begin
		req_beat_t b;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			b.kind = req_t'(in_ch.req_type);
			b.smp = in_ch.sample_in;
			b.cix = in_ch.coeff_index;
			b.cval = in_ch.coeff_value;
			if (b.kind == REQ_COEFF)
				loads_sent++;
			else
				samples_sent++;
			predict_outputs(b);
		end
	end

	// output backpressure
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// output checker
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			outs_seen++;
			if (expected_outs.size() == 0) begin
				$error("unexpected output beat sample_out=%0d", out_ch.sample_out);
				errors++;
			end else begin
				e = expected_outs.pop_front();
				if (out_ch.sample_out !== e.smp) begin
					$error("sample_out expected %0d got %0d", e.smp, out_ch.sample_out);
					errors++;
				end
				if (out_ch.last_of_run !== e.last) begin
					$error("last_of_run expected %0b got %0b", e.last, out_ch.last_of_run);
					errors++;
				end
				if (out_ch.saturated !== e.sat) begin
					$error("saturated expected %0b got %0b", e.sat, out_ch.saturated);
					errors++;
				end
				if (out_ch.dropped !== e.drop) begin
					$error("dropped expected %0b got %0b", e.drop, out_ch.dropped);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_INTERP: l_fac = val & 10'h3FF;
			CFG_DECIM:  m_fac = val & 10'h3FF;
			default:    tap_reg = val & 15'h7FFF;
		endcase
	endtask

	// wait until every beat is sent and every output is back, then let work finish
	task automatic drain();
		while (pending_reqs.size() > 0 || in_ch.valid || expected_outs.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic req_beat_t sample_beat(int v);
		req_beat_t b;
		b.kind = REQ_SAMPLE;
		b.smp = v[15:0];
		b.cix = 14'($urandom);
		b.cval = 18'($urandom);
		return b;
	endfunction

	function automatic req_beat_t coeff_beat(int ix, int v);
		req_beat_t b;
		b.kind = REQ_COEFF;
		b.smp = 16'($urandom);
		b.cix = ix[13:0];
		b.cval = v[17:0];
		return b;
	endfunction

	function automatic int rand_sample();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0: return 32767;
			1: return -32768;
			2: return 0;
			3: return ($urandom_range(1) != 0) ? 1 : -1;
			default: return $signed($urandom_range(65535) - 32768);
		endcase
	endfunction

	// random stream: mostly samples, some coefficient reloads anywhere
	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				pending_reqs.push_back(coeff_beat($urandom_range(N_TAPS - 1),
					$signed($urandom_range(262143)) - 131072));
			else
				pending_reqs.push_back(sample_beat(rand_sample()));
		end
	endtask

	task automatic set_mode(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
			default: begin send_idle_pct = 21; recv_stall_pct = 21; end
		endcase
	endtask

	task automatic run_phase(int lf, int mf, int nt, int n, int mode);
		drain();
		write_reg(CFG_INTERP, lf);
		write_reg(CFG_DECIM, mf);
		write_reg(CFG_TAPS, nt);
		set_mode(mode);
		queue_random(n);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_INTERP;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_SAMPLE;
		in_ch.sample_in = '0;
		in_ch.coeff_index = '0;
		in_ch.coeff_value = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		cycles = 0;
		outs_seen = 0;
		samples_sent = 0;
		loads_sent = 0;
		l_fac = 32'(INTERP_RST);
		m_fac = 32'(DECIM_RST);
		tap_reg = 32'(TAPS_RST);
		hist_wr = 0;
		out_phase = 0;
		foreach (hist_mem[i]) hist_mem[i] = 0;
		foreach (coeff_mem[i]) coeff_mem[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the low coefficients; every walk below stays under N_FILL, since
		// the tap count or the samples held in history bound it
		for (int i = 0; i < N_FILL; i++) begin
			if (i < 4)
				pending_reqs.push_back(coeff_beat(i, 131071));
			else if (i < 6)
				pending_reqs.push_back(coeff_beat(i, -131072));
			else
				pending_reqs.push_back(coeff_beat(i,
					$signed($urandom_range(262143)) - 131072));
		end
		// a few samples at the reset factors, extremes first
		pending_reqs.push_back(sample_beat(32767));
		pending_reqs.push_back(sample_beat(-32768));
		pending_reqs.push_back(sample_beat(0));
		pending_reqs.push_back(sample_beat(32767));
		pending_reqs.push_back(sample_beat(32767));
		pending_reqs.push_back(coeff_beat(N_TAPS - 1, 131071));

		// directed: identity rate, short filter, extremes saturate
		drain();
		write_reg(CFG_INTERP, 1);
		write_reg(CFG_DECIM, 1);
		write_reg(CFG_TAPS, 6);
		for (int i = 0; i < 4; i++) pending_reqs.push_back(sample_beat(32767));
		for (int i = 0; i < 4; i++) pending_reqs.push_back(sample_beat(-32768));
		pending_reqs.push_back(sample_beat(0));
		pending_reqs.push_back(sample_beat(1));

		// directed: too many outputs per sample, discarded ones flagged
		drain();
		write_reg(CFG_INTERP, 1023);
		write_reg(CFG_TAPS, 8);
		for (int i = 0; i < 3; i++) pending_reqs.push_back(sample_beat(rand_sample()));

		// directed: zero factors act as one, zero taps give zero outputs
		drain();
		write_reg(CFG_INTERP, 0);
		write_reg(CFG_DECIM, 0);
		write_reg(CFG_TAPS, 0);
		for (int i = 0; i < 3; i++) pending_reqs.push_back(sample_beat(32767));

		// directed: tap count beyond the store, history-limited walk
		drain();
		write_reg(CFG_INTERP, 3);
		write_reg(CFG_DECIM, 2);
		write_reg(CFG_TAPS, 32767);
		for (int i = 0; i < 3; i++) pending_reqs.push_back(sample_beat(rand_sample()));
		drain();
		write_reg(CFG_TAPS, 16384);
		pending_reqs.push_back(sample_beat(-32768));
		pending_reqs.push_back(sample_beat(32767));

		// directed: factor change midstream keeps the phase
		drain();
		write_reg(CFG_INTERP, 1);
		write_reg(CFG_DECIM, 1023);
		write_reg(CFG_TAPS, 32);
		for (int i = 0; i < 3; i++) pending_reqs.push_back(sample_beat(rand_sample()));

		// random phases across rates, filter lengths and idle patterns
		run_phase(160, 147, 48, 20, 0);
		run_phase(147, 160, 64, 20, 1);
		run_phase(1, 1, 16, 20, 2);
		run_phase(7, 3, 40, 20, 3);
		run_phase(1023, 1, 8, 16, 1);
		run_phase(1, 1023, 32, 16, 2);
		run_phase(5, 7, 30, 16, 3);
		run_phase(2, 7, 30, 16, 0);
		run_phase(441, 480, 60, 20, 3);

		drain();
		$display("covered %0d samples and %0d coefficient loads, %0d outputs checked",
			samples_sent, loads_sent, outs_seen);
		$display("rate settings from 1/1023 to 1023/1, tap counts 0 to beyond the store");
		if (errors == 0 && expected_outs.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
